FILE: hw/rtl/dhcprp_pkg.sv
// ----------------------------------------------------------------------------
// dhcprp_pkg
// Types and constants shared by the DHCP reply option parser.
// ----------------------------------------------------------------------------
package dhcprp_pkg;

	localparam int MAX_PAYLOAD = 2048;
	localparam int MIN_PACKET  = 548;

	localparam int OFF_W = 12;
	localparam logic [OFF_W-1:0] OFFSET_MAX    = '1;
	localparam logic [OFF_W-1:0] OFF_OPCODE    = 12'd0;
	localparam logic [OFF_W-1:0] OFF_YIADDR_LO = 12'd16;
	localparam logic [OFF_W-1:0] OFF_YIADDR_HI = 12'd19;
	localparam logic [OFF_W-1:0] OFF_COOKIE_LO = 12'd236;
	localparam logic [OFF_W-1:0] OFF_COOKIE_HI = 12'd239;
	localparam logic [OFF_W-1:0] OFF_OPTIONS   = 12'd240;
	localparam logic [OFF_W-1:0] OFF_MIN_LAST  = 12'(MIN_PACKET - 1);

	localparam logic [31:0] COOKIE       = 32'h6382_5363;
	localparam logic [31:0] DEFAULT_MASK = 32'hFFFF_FF00;

	localparam logic [7:0] OP_REPLY   = 8'd2;
	localparam logic [7:0] OPT_PAD    = 8'd0;
	localparam logic [7:0] OPT_MASK   = 8'd1;
	localparam logic [7:0] OPT_ROUTER = 8'd3;
	localparam logic [7:0] OPT_DNS    = 8'd6;
	localparam logic [7:0] OPT_TYPE   = 8'd53;
	localparam logic [7:0] OPT_SERVER = 8'd54;
	localparam logic [7:0] OPT_END    = 8'hFF;
	localparam logic [7:0] MSG_OFFER  = 8'd2;
	localparam logic [7:0] MSG_ACK    = 8'd5;

	localparam int OUT_DATA_W = 168;

	typedef enum logic [3:0] {
		PH_CODE = 4'b0001,
		PH_LEN  = 4'b0010,
		PH_VAL  = 4'b0100,
		PH_END  = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		EV_DROP   = 2'd0,
		EV_IGNORE = 2'd1,
		EV_OFFER  = 2'd2,
		EV_ACK    = 2'd3
	} event_t;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
		logic       last;
	} item_t;

	typedef struct packed {
		event_t      event_res;
		logic [31:0] offered_ip;
		logic [31:0] server_ip;
		logic [31:0] subnet_mask;
		logic [31:0] gateway_ip;
		logic [31:0] dns_ip;
		logic        have_offer;
		logic        have_ack;
	} result_t;

	function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = COOKIE[31:24];
			2'd1:    b = COOKIE[23:16];
			2'd2:    b = COOKIE[15:8];
			default: b = COOKIE[7:0];
		endcase
		return b;
	endfunction

endpackage

FILE: hw/rtl/dhcp_reply_option_parser_top.sv
// ----------------------------------------------------------------------------
// dhcp_reply_option_parser_top
// Byte-serial DHCP reply checker and option walker with offer/ack commit.
// ----------------------------------------------------------------------------
// Takes one UDP payload byte per cycle, with no gaps between packets, except while stalled.
// Each byte is staged in an input register and processed by the option walker
// when it advances out of that register; a result (only on the last byte) sits
// in an output register the cycle after. The input side stalls only when a
// result is waiting and the output is not taken.
// A clear transaction (tuser = 1) resets all negotiation state and gives no result.
// No clearing pass after reset.
module dhcp_reply_option_parser_top import dhcprp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // data_byte
	input  logic                  s_tuser,  // command
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// event_res, offered_ip, server_ip, subnet_mask, gateway_ip, dns_ip,
	// have_offer, have_ack, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata
);

	logic                  valid_s1;
	item_t                 item_s1;
	logic                  produces;
	logic                  advance;
	result_t               res;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	assign produces = !item_s1.command && item_s1.last;
	assign advance  = valid_s1 && (!produces || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			item_s1 <= '{command: s_tuser, data_byte: s_tdata, last: s_tlast};
	end

	dhcprp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && produces)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && produces)
			out_data_q <= {4'd0, res.have_ack, res.have_offer, res.dns_ip, res.gateway_ip,
				res.subnet_mask, res.server_ip, res.offered_ip, res.event_res};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_ack_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == EV_ACK |-> m_tdata[163] && m_tdata[162])
		else $error("ack result without both flags");

	a_offer_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == EV_OFFER |-> m_tdata[162] && !m_tdata[163])
		else $error("offer result with wrong flags");

	a_ack_needs_offer: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[163] |-> m_tdata[162])
		else $error("ack held without offer");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("staged byte lost while stalled");
`endif

endmodule

FILE: hw/rtl/dhcprp_core.sv
// ----------------------------------------------------------------------------
// dhcprp_core
// Per-byte header check, option walk and offer/ack commit; one byte per step.
// ----------------------------------------------------------------------------
module dhcprp_core import dhcprp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	output result_t res
);

	logic [OFF_W-1:0] off_q, off_d;
	logic             hdr_q, hdr_d;
	phase_t           phase_q, phase_d;
	logic [7:0]       code_q, code_d;
	logic [7:0]       left_q, left_d;
	logic [2:0]       pos_q, pos_d;
	logic [7:0]       msg_q, msg_d;
	logic             type_seen_q, type_seen_d;
	logic [3:0]       seen_q, seen_d;
	logic [31:0]      yi_q, yi_d;
	logic [31:0]      mask_q, mask_d;
	logic [31:0]      gw_q, gw_d;
	logic [31:0]      dns_q, dns_d;
	logic [31:0]      srv_q, srv_d;
	logic [31:0]      acc_q, acc_d;
	logic [31:0]      h_yi_q, h_yi_d;
	logic [31:0]      h_srv_q, h_srv_d;
	logic [31:0]      h_mask_q, h_mask_d;
	logic [31:0]      h_gw_q, h_gw_d;
	logic [31:0]      h_dns_q, h_dns_d;
	logic             offer_q, offer_d;
	logic             ack_q, ack_d;
	event_t           ev;
	logic             keep;
	logic [2:0]       pos_inc;
	logic [7:0]       left_dec;
	logic [7:0]       b;

	always_comb begin
		b        = item.data_byte;
		off_d    = (off_q == OFFSET_MAX) ? off_q : off_q + 1'b1;
		hdr_d    = hdr_q;
		phase_d  = phase_q;
		code_d   = code_q;
		left_d   = left_q;
		pos_d    = pos_q;
		msg_d    = msg_q;
		type_seen_d = type_seen_q;
		seen_d   = seen_q;
		yi_d     = yi_q;
		mask_d   = mask_q;
		gw_d     = gw_q;
		dns_d    = dns_q;
		srv_d    = srv_q;
		acc_d    = acc_q;
		h_yi_d   = h_yi_q;
		h_srv_d  = h_srv_q;
		h_mask_d = h_mask_q;
		h_gw_d   = h_gw_q;
		h_dns_d  = h_dns_q;
		offer_d  = offer_q;
		ack_d    = ack_q;
		ev       = EV_DROP;
		keep     = 1'b0;
		pos_inc  = pos_q + 3'd1;
		left_dec = left_q - 8'd1;

		if (32'(off_q) >= 32'(MAX_PAYLOAD))
			hdr_d = 1'b0;
		if (off_q == OFF_OPCODE && b != OP_REPLY)
			hdr_d = 1'b0;
		if (off_q >= OFF_YIADDR_LO && off_q <= OFF_YIADDR_HI)
			yi_d = {yi_q[23:0], b};
		if (off_q >= OFF_COOKIE_LO && off_q <= OFF_COOKIE_HI && b != cookie_byte(off_q[1:0]))
			hdr_d = 1'b0;

		if (off_q >= OFF_OPTIONS) begin
			unique case (phase_q)
				PH_CODE: begin
					if (b == OPT_END)
						phase_d = PH_END;
					else if (b != OPT_PAD) begin
						code_d  = b;
						phase_d = PH_LEN;
					end
				end
				PH_LEN: begin
					left_d = b;
					pos_d  = 3'd0;
					case (code_q) inside
						OPT_MASK, OPT_SERVER: keep = (b == 8'd4);
						OPT_ROUTER, OPT_DNS:  keep = (b >= 8'd4);
						OPT_TYPE:             keep = (b == 8'd1) && !type_seen_q;
						default:              keep = 1'b0;
					endcase
					if (!keep)
						code_d = OPT_PAD;
					phase_d = (b == 8'd0) ? PH_CODE : PH_VAL;
				end
				PH_VAL: begin
					if (code_q == OPT_TYPE) begin
						if (pos_q == 3'd0) begin
							msg_d       = b;
							type_seen_d = 1'b1;
							pos_d       = 3'd1;
						end
					end else if (code_q != OPT_PAD && pos_q < 3'd4) begin
						acc_d = {acc_q[23:0], b};
						pos_d = pos_inc;
						if (pos_inc == 3'd4) begin
							case (code_q)
								OPT_MASK:   begin mask_d = acc_d; seen_d[0] = 1'b1; end
								OPT_ROUTER: begin gw_d   = acc_d; seen_d[1] = 1'b1; end
								OPT_DNS:    begin dns_d  = acc_d; seen_d[2] = 1'b1; end
								default:    begin srv_d  = acc_d; seen_d[3] = 1'b1; end
							endcase
						end
					end
					left_d = left_dec;
					if (left_dec == 8'd0)
						phase_d = PH_CODE;
				end
				PH_END: begin
				end
				default: phase_d = PH_END;
			endcase
		end

		if (item.last) begin
			if (!hdr_d || off_q < OFF_MIN_LAST) begin
				ev = EV_DROP;
			end else begin
				ev = EV_IGNORE;
				if (msg_d == MSG_OFFER && type_seen_d && !offer_q) begin
					ev      = EV_OFFER;
					offer_d = 1'b1;
				end else if (msg_d == MSG_ACK && type_seen_d && offer_q) begin
					ev    = EV_ACK;
					ack_d = 1'b1;
				end
				if (ev == EV_OFFER || ev == EV_ACK) begin
					h_yi_d = yi_d;
					if (seen_d[3]) h_srv_d  = srv_d;
					if (seen_d[0]) h_mask_d = mask_d;
					if (seen_d[1]) h_gw_d   = gw_d;
					if (seen_d[2]) h_dns_d  = dns_d;
				end
			end
		end

		res.event_res   = ev;
		res.offered_ip  = h_yi_d;
		res.server_ip   = h_srv_d;
		res.subnet_mask = (h_mask_d != 32'd0) ? h_mask_d : DEFAULT_MASK;
		res.gateway_ip  = h_gw_d;
		res.dns_ip      = h_dns_d;
		res.have_offer  = offer_d;
		res.have_ack    = ack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q       <= '0;
			hdr_q       <= 1'b1;
			phase_q     <= PH_CODE;
			code_q      <= '0;
			left_q      <= '0;
			pos_q       <= '0;
			msg_q       <= '0;
			type_seen_q <= 1'b0;
			seen_q      <= '0;
			h_yi_q      <= '0;
			h_srv_q     <= '0;
			h_mask_q    <= '0;
			h_gw_q      <= '0;
			h_dns_q     <= '0;
			offer_q     <= 1'b0;
			ack_q       <= 1'b0;
		end else if (step) begin
			if (item.command || item.last) begin
				off_q       <= '0;
				hdr_q       <= 1'b1;
				phase_q     <= PH_CODE;
				code_q      <= '0;
				left_q      <= '0;
				pos_q       <= '0;
				msg_q       <= '0;
				type_seen_q <= 1'b0;
				seen_q      <= '0;
			end else begin
				off_q       <= off_d;
				hdr_q       <= hdr_d;
				phase_q     <= phase_d;
				code_q      <= code_d;
				left_q      <= left_d;
				pos_q       <= pos_d;
				msg_q       <= msg_d;
				type_seen_q <= type_seen_d;
				seen_q      <= seen_d;
			end
			if (item.command) begin
				h_yi_q   <= '0;
				h_srv_q  <= '0;
				h_mask_q <= '0;
				h_gw_q   <= '0;
				h_dns_q  <= '0;
				offer_q  <= 1'b0;
				ack_q    <= 1'b0;
			end else begin
				h_yi_q   <= h_yi_d;
				h_srv_q  <= h_srv_d;
				h_mask_q <= h_mask_d;
				h_gw_q   <= h_gw_d;
				h_dns_q  <= h_dns_d;
				offer_q  <= offer_d;
				ack_q    <= ack_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			yi_q   <= item.last ? '0 : yi_d;
			mask_q <= mask_d;
			gw_q   <= gw_d;
			dns_q  <= dns_d;
			srv_q  <= srv_d;
			acc_q  <= acc_d;
		end
	end

endmodule
